// ===== sv/ulpm_pkg.sv =====
// ----------------------------------------------------------------------------
// ulpm_pkg: shared types and constants of the line pattern matcher
// Register indexes, match modes, reset values of the pattern registers and
// the structs that pass between the top level and its pattern lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package ulpm_pkg;

  // Pattern slots held in the register file
  localparam int unsigned NumSlots  = 4;
  // Bytes per pattern register
  localparam int unsigned SlotBytes = 8;
  // Width of one pattern length field
  localparam int unsigned LenW      = 4;
  // Width of the line length counter (lines never exceed 255 kept bytes)
  localparam int unsigned LineLenW  = 8;
  localparam int unsigned HitW      = 16;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteLf = 8'h0A;

  // Reset contents: "ATE", "RDY", two empty slots
  localparam logic [CfgDataW-1:0] Pat0Reset    = 64'h0000_0000_0045_5441;
  localparam logic [CfgDataW-1:0] Pat1Reset    = 64'h0000_0000_0059_4452;
  localparam logic [CfgDataW-1:0] Pat2Reset    = 64'h0;
  localparam logic [CfgDataW-1:0] Pat3Reset    = 64'h0;
  localparam logic [15:0]         LensReset    = 16'h0033;
  localparam logic [7:0]          ModesReset   = 8'h0C;
  localparam logic [3:0]          EnablesReset = 4'h3;

  typedef logic [SlotBytes-1:0][7:0] pat_bytes_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPat0    = 3'd0,
    CfgPat1    = 3'd1,
    CfgPat2    = 3'd2,
    CfgPat3    = 3'd3,
    CfgLens    = 3'd4,
    CfgModes   = 3'd5,
    CfgEnables = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModePrefix   = 2'd0,
    ModeSuffix   = 2'd1,
    ModeContains = 2'd2,
    ModeExact    = 2'd3
  } mode_e;

  // Per-byte control broadcast to every lane
  typedef struct packed {
    logic [7:0]          data_byte;
    logic                append;
    logic                clear;
    logic [LineLenW-1:0] line_len;
    logic [LineLenW-1:0] line_len_new;
  } lane_ctl_t;

  // Lane verdict and its incremented hit count
  typedef struct packed {
    logic            hit;
    logic [HitW-1:0] hits_next;
  } lane_stat_t;

  // One result item
  typedef struct packed {
    logic              line_valid;
    logic              matched;
    logic [1:0]        pattern_index;
    logic [HitW-1:0]   pattern_hits;
    logic              call_end;
    logic              call_matched;
    logic [TotalW-1:0] matched_calls_total;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/ulpm_byte_cell.sv =====
// ----------------------------------------------------------------------------
// ulpm_byte_cell: one byte of the line tail window
// Holds one kept byte and hands it to the next cell when a byte is appended.
// Compares the byte it will hold against the matching byte of every pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module ulpm_byte_cell #(
  parameter int unsigned NumLanes = 4,
  parameter int unsigned CellIdx  = 0
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      shift_i,
  input  wire logic                                      clear_i,
  input  wire logic [7:0]                                byte_i,
  input  wire logic                                      valid_i,
  input  wire ulpm_pkg::pat_bytes_t [NumLanes-1:0]       pat_i,
  input  wire logic [NumLanes-1:0][ulpm_pkg::LenW-1:0]   len_i,
  output logic [7:0]                                     byte_o,
  output logic                                           valid_o,
  output logic [NumLanes-1:0]                            match_o
);

  logic [7:0] byte_q;
  logic       valid_q;
  logic [7:0] view_byte;
  logic       view_valid;

  // Look at the contents after this step's shift
  assign view_byte  = shift_i ? byte_i  : byte_q;
  assign view_valid = shift_i ? valid_i : valid_q;

  // Compare against pattern byte (len - 1 - CellIdx) where the pattern reaches
  always_comb begin
    logic [ulpm_pkg::LenW-1:0] sel;
    for (int k = 0; k < NumLanes; k++) begin
      sel = len_i[k] - ulpm_pkg::LenW'(CellIdx) - ulpm_pkg::LenW'(1);
      if (ulpm_pkg::LenW'(CellIdx) >= len_i[k]) begin
        match_o[k] = 1'b1;
      end else begin
        match_o[k] = view_valid && (view_byte == pat_i[k][sel[2:0]]);
      end
    end
  end

  // Hold the byte; drop it when the line closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ===== sv/ulpm_lane.sv =====
// ----------------------------------------------------------------------------
// ulpm_lane: match state and hit counter of one pattern
// Tracks whether the line still starts with the pattern and whether the
// pattern was seen anywhere, judges the line in the pattern's mode and keeps
// the saturating hit counter.
// ----------------------------------------------------------------------------
`default_nettype none

module ulpm_lane (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ulpm_pkg::lane_ctl_t           ctl_i,
  input  wire logic                          enable_i,
  input  wire ulpm_pkg::mode_e               mode_i,
  input  wire logic [ulpm_pkg::LenW-1:0]     len_i,
  input  wire ulpm_pkg::pat_bytes_t          pat_i,
  input  wire logic                          tail_match_i,
  input  wire logic                          bump_i,
  output ulpm_pkg::lane_stat_t               stat_o
);

  logic                      alive_q, alive_d;
  logic                      contain_q, contain_d;
  logic [ulpm_pkg::HitW-1:0] cnt_q;
  logic [ulpm_pkg::LineLenW-1:0] len_ext;
  logic                      kill;
  logic                      hit;

  assign len_ext = ulpm_pkg::LineLenW'(len_i);

  // Drop the prefix flag when a byte inside the pattern length differs
  assign kill = (ctl_i.line_len < len_ext) &&
                (ctl_i.data_byte != pat_i[ctl_i.line_len[2:0]]);
  assign alive_d   = alive_q & ~(ctl_i.append & kill);
  assign contain_d = contain_q | (ctl_i.append & tail_match_i);

  // Judge the line as it stands after this byte
  always_comb begin
    unique case (mode_i)
      ulpm_pkg::ModePrefix:   hit = alive_d && (ctl_i.line_len_new >= len_ext);
      ulpm_pkg::ModeSuffix:   hit = tail_match_i;
      ulpm_pkg::ModeContains: hit = (len_i == '0) || contain_d;
      ulpm_pkg::ModeExact:    hit = alive_d && (ctl_i.line_len_new == len_ext);
      default:                hit = 1'b0;
    endcase
  end

  assign stat_o.hit       = enable_i && hit;
  assign stat_o.hits_next = (cnt_q == '1) ? cnt_q : cnt_q + ulpm_pkg::HitW'(1);

  // Advance line flags; restart them when the line closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q   <= 1'b1;
      contain_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (ctl_i.clear) begin
        alive_q   <= 1'b1;
        contain_q <= 1'b0;
      end else begin
        alive_q   <= alive_d;
        contain_q <= contain_d;
      end
      if (bump_i) begin
        cnt_q <= stat_o.hits_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/urc_line_pattern_matcher.sv =====
// ----------------------------------------------------------------------------
// urc_line_pattern_matcher: multi-pattern matcher for modem result lines
// Splits the byte stream into lines at CR or LF, matches each line against
// the enabled patterns and counts hits per pattern and matched calls.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   data_byte_i, last_of_call_i
//   out      output     out_valid_o / out_stall_i line_valid_o .. matched_calls_total_o
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One byte is taken in every cycle while in_stall_o is low; a line is judged in the
// cycle its closing byte arrives, against a tail window of MAX_PATTERN_LEN byte cells.
// A result is registered, in the skid register when the output register is stalled.
// The output holds two results; in_stall_o is high only while both are held.
// Reset restores the pattern registers and clears all counters at once.
//
`default_nettype none

module urc_line_pattern_matcher #(
  parameter int unsigned NUM_PATTERNS    = 4,
  parameter int unsigned MAX_PATTERN_LEN = 8,
  parameter int unsigned MAX_LINE_LEN    = 255
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [7:0]                        data_byte_i,
  input  wire logic                              last_of_call_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   line_valid_o,
  output logic                                   matched_o,
  output logic [1:0]                             pattern_index_o,
  output logic [ulpm_pkg::HitW-1:0]              pattern_hits_o,
  output logic                                   call_end_o,
  output logic                                   call_matched_o,
  output logic [ulpm_pkg::TotalW-1:0]            matched_calls_total_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ulpm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [ulpm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned NumLanes =
      (NUM_PATTERNS < ulpm_pkg::NumSlots) ? NUM_PATTERNS : ulpm_pkg::NumSlots;
  localparam int unsigned NumCells = MAX_PATTERN_LEN;

  // Configuration registers
  ulpm_pkg::pat_bytes_t [ulpm_pkg::NumSlots-1:0] pat_q;
  logic [15:0] lens_q;
  logic [7:0]  modes_q;
  logic [3:0]  enables_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q[0]  <= ulpm_pkg::Pat0Reset;
      pat_q[1]  <= ulpm_pkg::Pat1Reset;
      pat_q[2]  <= ulpm_pkg::Pat2Reset;
      pat_q[3]  <= ulpm_pkg::Pat3Reset;
      lens_q    <= ulpm_pkg::LensReset;
      modes_q   <= ulpm_pkg::ModesReset;
      enables_q <= ulpm_pkg::EnablesReset;
    end else if (cfg_we_i) begin
      unique case (ulpm_pkg::cfg_idx_e'(cfg_idx_i))
        ulpm_pkg::CfgPat0:    pat_q[0]  <= cfg_data_i;
        ulpm_pkg::CfgPat1:    pat_q[1]  <= cfg_data_i;
        ulpm_pkg::CfgPat2:    pat_q[2]  <= cfg_data_i;
        ulpm_pkg::CfgPat3:    pat_q[3]  <= cfg_data_i;
        ulpm_pkg::CfgLens:    lens_q    <= cfg_data_i[15:0];
        ulpm_pkg::CfgModes:   modes_q   <= cfg_data_i[7:0];
        ulpm_pkg::CfgEnables: enables_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Saturate each pattern length to the window depth
  ulpm_pkg::pat_bytes_t [NumLanes-1:0]          lane_pat;
  logic [NumLanes-1:0][ulpm_pkg::LenW-1:0]      lane_len;

  always_comb begin
    logic [ulpm_pkg::LenW-1:0] raw;
    for (int k = 0; k < NumLanes; k++) begin
      raw         = lens_q[ulpm_pkg::LenW*k +: ulpm_pkg::LenW];
      lane_len[k] = (raw > ulpm_pkg::LenW'(MAX_PATTERN_LEN)) ?
                    ulpm_pkg::LenW'(MAX_PATTERN_LEN) : raw;
      lane_pat[k] = pat_q[k];
    end
  end

  // Line state and per-byte decode
  logic [ulpm_pkg::LineLenW-1:0] line_len_q, line_len_new;
  logic accept, eol, append, done, last, close_line;

  assign accept = in_valid_i && !in_stall_o;
  assign last   = accept && last_of_call_i;
  assign eol    = (data_byte_i == ulpm_pkg::ByteCr) || (data_byte_i == ulpm_pkg::ByteLf);
  assign append = accept && !eol && (line_len_q < ulpm_pkg::LineLenW'(MAX_LINE_LEN));
  assign line_len_new = append ? line_len_q + ulpm_pkg::LineLenW'(1) : line_len_q;
  assign done       = accept && (eol || last_of_call_i) && (line_len_new != '0);
  assign close_line = done || last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q <= '0;
    end else if (close_line) begin
      line_len_q <= '0;
    end else begin
      line_len_q <= line_len_new;
    end
  end

  // Tail window: a chain of byte cells, newest byte in cell 0
  logic [NumCells-1:0][7:0]          cell_byte;
  logic [NumCells-1:0]               cell_valid;
  logic [NumCells-1:0][NumLanes-1:0] cell_match;

  for (genvar m = 0; m < NumCells; m++) begin : g_cell
    logic [7:0] in_byte;
    logic       in_valid;
    if (m == 0) begin : g_head
      assign in_byte  = data_byte_i;
      assign in_valid = 1'b1;
    end else begin : g_link
      assign in_byte  = cell_byte[m-1];
      assign in_valid = cell_valid[m-1];
    end
    ulpm_byte_cell #(
      .NumLanes (NumLanes),
      .CellIdx  (m)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (append),
      .clear_i (close_line),
      .byte_i  (in_byte),
      .valid_i (in_valid),
      .pat_i   (lane_pat),
      .len_i   (lane_len),
      .byte_o  (cell_byte[m]),
      .valid_o (cell_valid[m]),
      .match_o (cell_match[m])
    );
  end

  // Combine cell compares into one tail match per pattern
  logic [NumLanes-1:0] tail_match;

  always_comb begin
    tail_match = '1;
    for (int m = 0; m < NumCells; m++) begin
      tail_match = tail_match & cell_match[m];
    end
  end

  // Pattern lanes
  ulpm_pkg::lane_ctl_t                 lane_ctl;
  ulpm_pkg::lane_stat_t [NumLanes-1:0] lane_stat;
  logic [NumLanes-1:0]                 bump;

  assign lane_ctl.data_byte    = data_byte_i;
  assign lane_ctl.append       = append;
  assign lane_ctl.clear        = close_line;
  assign lane_ctl.line_len     = line_len_q;
  assign lane_ctl.line_len_new = line_len_new;

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    ulpm_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (lane_ctl),
      .enable_i     (enables_q[k]),
      .mode_i       (ulpm_pkg::mode_e'(modes_q[2*k +: 2])),
      .len_i        (lane_len[k]),
      .pat_i        (lane_pat[k]),
      .tail_match_i (tail_match[k]),
      .bump_i       (bump[k]),
      .stat_o       (lane_stat[k])
    );
  end

  // Pick the lowest-numbered matching pattern
  logic                      any_hit;
  logic [1:0]                win;
  logic [ulpm_pkg::HitW-1:0] win_hits;

  always_comb begin
    any_hit  = 1'b0;
    win      = '0;
    win_hits = '0;
    for (int k = NumLanes - 1; k >= 0; k--) begin
      if (lane_stat[k].hit) begin
        any_hit  = 1'b1;
        win      = 2'(k);
        win_hits = lane_stat[k].hits_next;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumLanes; k++) begin
      bump[k] = done && any_hit && (win == 2'(k));
    end
  end

  // Call bookkeeping
  logic                        call_hit_q, call_hit_now;
  logic [ulpm_pkg::TotalW-1:0] calls_q, calls_d;

  assign call_hit_now = call_hit_q || (done && any_hit);
  assign calls_d = (last && call_hit_now && (calls_q != '1)) ?
                   calls_q + ulpm_pkg::TotalW'(1) : calls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      call_hit_q <= 1'b0;
      calls_q    <= '0;
    end else begin
      call_hit_q <= last ? 1'b0 : call_hit_now;
      calls_q    <= calls_d;
    end
  end

  // Assemble the result item
  ulpm_pkg::res_t res;
  logic           emit;

  assign emit                    = close_line;
  assign res.line_valid          = done;
  assign res.matched             = done && any_hit;
  assign res.pattern_index       = (done && any_hit) ? win : 2'd0;
  assign res.pattern_hits        = (done && any_hit) ? win_hits : '0;
  assign res.call_end            = last;
  assign res.call_matched        = last && call_hit_now;
  assign res.matched_calls_total = calls_d;

  // Two-deep output buffer: output register plus skid register
  ulpm_pkg::res_t out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           out_take;

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_take) begin
      skid_valid_q <= emit;
    end else begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !out_take) begin
      if (emit) begin
        skid_q <= res;
      end
    end else if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign line_valid_o          = out_q.line_valid;
  assign matched_o             = out_q.matched;
  assign pattern_index_o       = out_q.pattern_index;
  assign pattern_hits_o        = out_q.pattern_hits;
  assign call_end_o            = out_q.call_end;
  assign call_matched_o        = out_q.call_matched;
  assign matched_calls_total_o = out_q.matched_calls_total;

endmodule

`default_nettype wire

// ===== sv/ulpm_checker.sv =====
// ----------------------------------------------------------------------------
// ulpm_checker: port-level checks of the line pattern matcher
// Watches the top level's ports and flags results or stalls that the
// matcher must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module ulpm_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_stall_o,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic                              line_valid_o,
  input  wire logic                              matched_o,
  input  wire logic [1:0]                        pattern_index_o,
  input  wire logic [ulpm_pkg::HitW-1:0]         pattern_hits_o,
  input  wire logic                              call_end_o,
  input  wire logic                              call_matched_o
);

  // Hold a stalled item on the output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // Input stall only follows a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output");

  // Every item closes a line or a call
  a_item_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_valid_o || call_end_o) &&
                    (!matched_o || line_valid_o) &&
                    (!call_matched_o || call_end_o))
    else $error("result item with inconsistent flags");

  // A match reports a nonzero count; no match reports zeros
  a_hit_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (matched_o && pattern_hits_o != '0) ||
                    (!matched_o && pattern_hits_o == '0 && pattern_index_o == 2'd0))
    else $error("hit fields disagree with match flag");

endmodule

bind urc_line_pattern_matcher ulpm_checker u_ulpm_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for urc_line_pattern_matcher
// Streams directed and random modem text through the byte channel under
// several pattern settings and predicts every line and call verdict. Each
// result item is compared field by field with the oldest prediction. The input
// channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int ClkPeriod     = 4;
  localparam int MaxLine       = 255;
  localparam int MaxPatLen     = 8;
  localparam int PhaseItems    = 50;
  localparam int NumPhases     = 6;
  localparam int TimeoutCycles = 400_000;

  typedef logic [ulpm_pkg::CfgDataW-1:0] pat_word_t;

  typedef struct {
    pat_word_t   pat[ulpm_pkg::NumSlots];
    logic [15:0] lens;
    logic [7:0]  modes;
    logic [3:0]  en;
  } setting_t;

  // Predict line and call verdicts and hold the result items still awaited
  class line_verdict_board;
    pat_word_t                   pats[ulpm_pkg::NumSlots];
    logic [15:0]                 lens;
    logic [7:0]                  modes;
    logic [3:0]                  enables;
    logic [7:0]                  line_len;
    logic [63:0]                 tail;
    logic [3:0]                  prefix_alive;
    logic [3:0]                  contain_seen;
    logic                        call_hit;
    logic [ulpm_pkg::HitW-1:0]   pat_hits[ulpm_pkg::NumSlots];
    logic [ulpm_pkg::TotalW-1:0] calls_matched;
    ulpm_pkg::res_t              awaited[$];
    int                          failures;

    function new();
      pats[0] = ulpm_pkg::Pat0Reset;
      pats[1] = ulpm_pkg::Pat1Reset;
      pats[2] = ulpm_pkg::Pat2Reset;
      pats[3] = ulpm_pkg::Pat3Reset;
      lens = ulpm_pkg::LensReset;
      modes = ulpm_pkg::ModesReset;
      enables = ulpm_pkg::EnablesReset;
      clear_line();
      call_hit = 1'b0;
      foreach (pat_hits[k]) pat_hits[k] = '0;
      calls_matched = '0;
      failures = 0;
    endfunction

    function void set_reg(ulpm_pkg::cfg_idx_e idx, pat_word_t v);
      case (idx)
        ulpm_pkg::CfgPat0, ulpm_pkg::CfgPat1,
        ulpm_pkg::CfgPat2, ulpm_pkg::CfgPat3: pats[idx] = v;
        ulpm_pkg::CfgLens:    lens = v[15:0];
        ulpm_pkg::CfgModes:   modes = v[7:0];
        ulpm_pkg::CfgEnables: enables = v[3:0];
        default: ;
      endcase
    endfunction

    // Saturate the length field at the widest pattern
    function int len_of(int k);
      int v;
      v = lens[4*k +: 4];
      return (v > MaxPatLen) ? MaxPatLen : v;
    endfunction

    function logic [7:0] byte_of(int k, int j);
      return pats[k][8*(j % 8) +: 8];
    endfunction

    // Compare the newest n kept bytes with the first n pattern bytes
    function bit tail_has(int k, int n);
      int m;
      if (n > line_len) return 1'b0;
      for (int j = 0; j < n; j++) begin
        m = n - 1 - j;
        if (tail[8*m +: 8] != byte_of(k, j)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void clear_line();
      line_len = '0;
      tail = '0;
      prefix_alive = '1;
      contain_seen = '0;
    endfunction

    // Keep a byte of the line, drop it past the line limit
    function void append(logic [7:0] b);
      if (line_len >= MaxLine) return;
      for (int k = 0; k < ulpm_pkg::NumSlots; k++) begin
        if (line_len < len_of(k) && b != byte_of(k, line_len)) prefix_alive[k] = 1'b0;
      end
      tail = {tail[55:0], b};
      line_len++;
      for (int k = 0; k < ulpm_pkg::NumSlots; k++) begin
        if (tail_has(k, len_of(k))) contain_seen[k] = 1'b1;
      end
    endfunction

    // Return the lowest enabled pattern that matches, or -1
    function int judge();
      int              n;
      ulpm_pkg::mode_e mode;
      bit              hit;
      for (int k = 0; k < ulpm_pkg::NumSlots; k++) begin
        n = len_of(k);
        mode = ulpm_pkg::mode_e'(modes[2*k +: 2]);
        hit = 1'b0;
        if (!enables[k]) continue;
        case (mode)
          ulpm_pkg::ModePrefix:   hit = prefix_alive[k] && line_len >= n;
          ulpm_pkg::ModeSuffix:   hit = tail_has(k, n);
          ulpm_pkg::ModeContains: hit = (n == 0) || contain_seen[k];
          ulpm_pkg::ModeExact:    hit = prefix_alive[k] && line_len == n;
        endcase
        if (hit) return k;
      end
      return -1;
    endfunction

    // Advance the line state by one accepted item, queue any result it causes
    function void note_item(logic [7:0] b, logic last);
      bit             eol;
      bit             done;
      int             win;
      ulpm_pkg::res_t r;
      eol = (b == ulpm_pkg::ByteCr) || (b == ulpm_pkg::ByteLf);
      win = -1;
      r = '0;
      if (!eol) append(b);
      done = (eol || last) && line_len > 0;
      if (done) begin
        win = judge();
        if (win >= 0) begin
          if (pat_hits[win] != '1) pat_hits[win]++;
          r.matched = 1'b1;
          r.pattern_index = win[1:0];
          r.pattern_hits = pat_hits[win];
          call_hit = 1'b1;
        end
        clear_line();
      end
      if (last) begin
        r.call_matched = call_hit;
        if (call_hit && calls_matched != '1) calls_matched++;
        call_hit = 1'b0;
        clear_line();
      end
      if (done || last) begin
        r.line_valid = done;
        r.call_end = last;
        r.matched_calls_total = calls_matched;
        awaited.push_back(r);
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(ulpm_pkg::res_t got);
      ulpm_pkg::res_t want;
      if (awaited.size() == 0) begin
        $error("result item with no prediction waiting");
        failures++;
        return;
      end
      want = awaited.pop_front();
      check_field("line_valid", want.line_valid, got.line_valid);
      check_field("matched", want.matched, got.matched);
      check_field("pattern_index", want.pattern_index, got.pattern_index);
      check_field("pattern_hits", want.pattern_hits, got.pattern_hits);
      check_field("call_end", want.call_end, got.call_end);
      check_field("call_matched", want.call_matched, got.call_matched);
      check_field("matched_calls_total", want.matched_calls_total,
                  got.matched_calls_total);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [7:0]                  data_byte = '0;
  logic                        last_of_call = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        line_valid;
  logic                        matched;
  logic [1:0]                  pattern_index;
  logic [ulpm_pkg::HitW-1:0]   pattern_hits;
  logic                        call_end;
  logic                        call_matched;
  logic [ulpm_pkg::TotalW-1:0] matched_calls_total;
  logic                        cfg_we = 1'b0;
  ulpm_pkg::cfg_idx_e          cfg_idx = ulpm_pkg::CfgPat0;
  pat_word_t                   cfg_data = '0;

  line_verdict_board board = new();
  int                items_sent = 0;
  int                send_quiet = 0;
  int                recv_quiet = 0;

  urc_line_pattern_matcher uut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .data_byte_i           (data_byte),
    .last_of_call_i        (last_of_call),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .line_valid_o          (line_valid),
    .matched_o             (matched),
    .pattern_index_o       (pattern_index),
    .pattern_hits_o        (pattern_hits),
    .call_end_o            (call_end),
    .call_matched_o        (call_matched),
    .matched_calls_total_o (matched_calls_total),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_data_i            (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Idle cycles before the next item; now and then a stretch with none
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Line content byte, biased toward pattern-like text, never a line end
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = 8'h00;
      1: c = 8'hFF;
      2: c = "A";
      3: c = "T";
      4: c = "O";
      5: c = "K";
      default: c = 8'($urandom_range(0, 255));
    endcase
    if (c == ulpm_pkg::ByteCr || c == ulpm_pkg::ByteLf) c = "+";
    return c;
  endfunction

  // Offer one item and hold it until taken
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_of_call <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$], input bit close);
    foreach (q[i]) send_byte(q[i], close && i == q.size() - 1);
  endtask

  // Drop valid and wait until every predicted result item is taken
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (board.awaited.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(ulpm_pkg::cfg_idx_e idx, pat_word_t v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  task automatic apply_setting(setting_t s);
    put_reg(ulpm_pkg::CfgPat0, s.pat[0]);
    put_reg(ulpm_pkg::CfgPat1, s.pat[1]);
    put_reg(ulpm_pkg::CfgPat2, s.pat[2]);
    put_reg(ulpm_pkg::CfgPat3, s.pat[3]);
    put_reg(ulpm_pkg::CfgLens, pat_word_t'(s.lens));
    put_reg(ulpm_pkg::CfgModes, pat_word_t'(s.modes));
    put_reg(ulpm_pkg::CfgEnables, pat_word_t'(s.en));
    cfg_we <= 1'b0;
  endtask

  // Stall the result channel for a drawn number of cycles per item
  task automatic sink_one_result();
    int hold;
    hold = draw_gap(recv_quiet);
    if (hold > 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
  endtask

  initial begin
    forever sink_one_result();
  end

  // Note accepted items before checking taken results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_item(data_byte, last_of_call);
      if (out_valid && !out_stall) begin
        board.check_result(ulpm_pkg::res_t'({line_valid, matched, pattern_index,
                                             pattern_hits, call_end, call_matched,
                                             matched_calls_total}));
      end
    end
  end

  initial begin
    setting_t   s;
    logic [7:0] q[$];
    int         budget;
    int         shape;
    int         k;
    int         n;
    bit         close;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset patterns: prefix hit, exact hit, empty line, call end on CR, empty call
    send_bytes('{"A", "T", "E", ulpm_pkg::ByteCr}, 1'b0);
    send_bytes('{"R", "D", "Y", ulpm_pkg::ByteLf}, 1'b0);
    send_bytes('{ulpm_pkg::ByteLf}, 1'b0);
    send_bytes('{"A", "T", ulpm_pkg::ByteCr}, 1'b1);
    send_bytes('{ulpm_pkg::ByteLf}, 1'b1);

    // Overlong length field, zero pattern byte, empty pattern, lowest index wins
    settle();
    s.pat[0] = '1;
    s.pat[1] = 64'h4B00;
    s.pat[2] = '0;
    s.pat[3] = 64'h4B4F;
    s.lens = {4'd2, 4'd0, 4'd2, 4'hF};
    s.modes = {ulpm_pkg::ModePrefix, ulpm_pkg::ModeSuffix,
               ulpm_pkg::ModeContains, ulpm_pkg::ModeExact};
    s.en = 4'hF;
    apply_setting(s);
    send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 ulpm_pkg::ByteLf}, 1'b0);
    send_bytes('{"A", 8'h00, "K", ulpm_pkg::ByteCr}, 1'b0);
    send_bytes('{"Z"}, 1'b1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      case (ph)
        1: s = '{pat: '{default: '0}, lens: '0, modes: '0, en: '0};
        2: s = '{pat: '{default: '1}, lens: '1, modes: '1, en: '1};
        default: begin
          foreach (s.pat[i]) begin
            for (int j = 0; j < 8; j++) begin
              s.pat[i][8*j +: 8] = ($urandom_range(0, 15) == 0) ?
                                   8'($urandom_range(0, 255)) : pick_char();
            end
          end
          for (int i = 0; i < ulpm_pkg::NumSlots; i++) begin
            s.lens[4*i +: 4] = 4'($urandom_range(0, 11));
            if (s.lens[4*i +: 4] > MaxPatLen) s.lens[4*i +: 4] = 4'($urandom_range(9, 15));
          end
          s.modes = 8'($urandom_range(0, 255));
          s.en = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom_range(0, 15));
        end
      endcase
      apply_setting(s);

      // Run one line past the limit with a pattern straddling the cut
      if (ph == 3) begin
        q.delete();
        k = $urandom_range(0, ulpm_pkg::NumSlots - 1);
        repeat (MaxLine - 3) q.push_back(pick_char());
        for (int j = 0; j < board.len_of(k); j++) q.push_back(board.byte_of(k, j));
        while (q.size() <= MaxLine) q.push_back(pick_char());
        q.push_back(ulpm_pkg::ByteCr);
        send_bytes(q, 1'b0);
      end

      budget = items_sent + PhaseItems;
      while (items_sent < budget) begin
        q.delete();
        close = 1'b0;
        shape = $urandom_range(0, 11);
        if (shape == 0) begin
          // raw noise, line ends included
          repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
          close = ($urandom_range(0, 3) == 0);
        end else if (shape == 1) begin
          // call closed by a lone line end byte
          q.push_back($urandom_range(0, 1) ? ulpm_pkg::ByteCr : ulpm_pkg::ByteLf);
          close = 1'b1;
        end else begin
          // wrap a pattern in filler, sometimes with one byte broken
          k = $urandom_range(0, ulpm_pkg::NumSlots - 1);
          n = board.len_of(k);
          if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) q.push_back(pick_char());
          for (int j = 0; j < n; j++) q.push_back(board.byte_of(k, j));
          if (q.size() > 0 && $urandom_range(0, 4) == 0) begin
            q[$urandom_range(0, q.size() - 1)] = pick_char();
          end
          if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) q.push_back(pick_char());
          if (q.size() == 0) q.push_back(pick_char());
          case ($urandom_range(0, 7))
            0, 1: q.push_back(ulpm_pkg::ByteCr);
            2: q.push_back(ulpm_pkg::ByteLf);
            3: begin
              q.push_back(ulpm_pkg::ByteCr);
              q.push_back(ulpm_pkg::ByteLf);
            end
            4: close = 1'b1;
            5: begin
              q.push_back($urandom_range(0, 1) ? ulpm_pkg::ByteCr : ulpm_pkg::ByteLf);
              close = 1'b1;
            end
            default: ;  // leave the line open
          endcase
        end
        send_bytes(q, close);
      end
    end

    settle();
    if (board.awaited.size() != 0) begin
      $error("%0d predicted result items never arrived", board.awaited.size());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("urc_line_pattern_matcher: match");
    end else begin
      $display("urc_line_pattern_matcher: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("urc_line_pattern_matcher: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ulpm_pkg.sv
sv/ulpm_byte_cell.sv
sv/ulpm_lane.sv
sv/urc_line_pattern_matcher.sv
sv/ulpm_checker.sv
verif/tb.sv
